// ===== src/flha_pkg.sv =====
package flha_pkg;

  // Default geometry of the heap.
  localparam int ADDR_BITS_DEF    = 12;
  localparam int HEADER_BYTES_DEF = 4;

  // Register reset values.
  localparam int TOP_RESET    = 4095;
  localparam int BOTTOM_RESET = 1;

  // Configuration register indexes.
  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] REG_HEAP_TOP    = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_HEAP_BOTTOM = 1'b1;

  // Commands.
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_OK          = 2'd0,
    STAT_NO_HEAP     = 2'd1,
    STAT_BAD_PTR     = 2'd2,
    STAT_DOUBLE_FREE = 2'd3
  } status_t;

endpackage

// ===== src/flha_req_if.sv =====
interface flha_req_if
  import flha_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic                 command;
  logic [ADDR_BITS-1:0] request_length;
  logic [ADDR_BITS-1:0] block_address;

  modport source (output valid, output command, output request_length,
                  output block_address, input ready);
  modport sink (input valid, input command, input request_length,
                input block_address, output ready);
endinterface

// ===== src/flha_rsp_if.sv =====
interface flha_rsp_if
  import flha_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic [ADDR_BITS-1:0] address;
  logic [1:0]           status;
  logic [ADDR_BITS-1:0] break_address;

  modport source (output valid, output address, output status,
                  output break_address, input ready);
  modport sink (input valid, input address, input status,
                input break_address, output ready);
endinterface

// ===== src/free_list_heap_allocator_unit.sv =====
// Heap allocator with an address-ordered free list that grows downward.
// The in_item channel takes one command at a time (allocate or free); each
// command gives exactly one item on out_item with the payload address, a
// status code and the heap break after the command. Configuration writes
// (heap top, heap bottom) go through cfg_we/cfg_index/cfg_data; the user must
// write them only while the block is idle, which the block does not enforce;
// writing the heap top resets the break and empties the list. Segment headers
// live in a header memory with a write port and a read port with registered
// read data. One sequencer walks the free list, one header at a time: one
// state reads a header and a second state checks it.
// The next command is taken once the current one has handed its result to
// the output register; the result waits there while out_item.ready is low,
// and a following command finishes only after that register is emptied.
// After reset the header memory is cleared, one entry per cycle, through all
// 2^ADDR_BITS entries; in_item.ready stays low meanwhile.
module free_list_heap_allocator_unit
  import flha_pkg::*;
#(
  parameter int ADDR_BITS    = ADDR_BITS_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  flha_req_if.sink                in_item,
  flha_rsp_if.source              out_item,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [ADDR_BITS-1:0]    cfg_data
);

  localparam int AW    = ADDR_BITS;
  localparam int DEPTH = 1 << AW;
  localparam logic [AW-1:0] HB = AW'(HEADER_BYTES);

  typedef struct packed {
    logic [AW-1:0] size;
    logic [AW-1:0] next;
  } hdr_t;

  typedef enum logic [35:0] {
    S_IDLE  = 36'd1 << 0,  S_CLR   = 36'd1 << 1,  S_FIN   = 36'd1 << 2,
    S_A_RD  = 36'd1 << 3,  S_A_CHK = 36'd1 << 4,  S_A_L1  = 36'd1 << 5,
    S_A_L2  = 36'd1 << 6,  S_A_L3  = 36'd1 << 7,  S_A_FIT = 36'd1 << 8,
    S_A_B1  = 36'd1 << 9,  S_A_B2  = 36'd1 << 10, S_F_CK0 = 36'd1 << 11,
    S_F_CK1 = 36'd1 << 12, S_F_WRD = 36'd1 << 13, S_F_WCK = 36'd1 << 14,
    S_F_S1  = 36'd1 << 15, S_F_S1A = 36'd1 << 16, S_F_S1B = 36'd1 << 17,
    S_F_S1C = 36'd1 << 18, S_F_S1D = 36'd1 << 19, S_F_S2  = 36'd1 << 20,
    S_F_S2A = 36'd1 << 21, S_F_S2B = 36'd1 << 22, S_F_S2C = 36'd1 << 23,
    S_F_S2D = 36'd1 << 24, S_F_S2E = 36'd1 << 25, S_F_S3  = 36'd1 << 26,
    S_F_S3A = 36'd1 << 27, S_F_S3B = 36'd1 << 28, S_F_S3C = 36'd1 << 29,
    S_F_S3D = 36'd1 << 30, S_F_S3E = 36'd1 << 31, S_F_S4  = 36'd1 << 32,
    S_F_S4A = 36'd1 << 33, S_F_S4B = 36'd1 << 34, S_F_S4C = 36'd1 << 35
  } state_t;

  // End address of a segment, kept wide so that it never wraps.
  function automatic logic [AW+1:0] seg_end(input logic [AW-1:0] a,
                                            input logic [AW-1:0] sz);
    return {2'b00, a} + {2'b00, sz} + (AW+2)'(HEADER_BYTES);
  endfunction

  // Header memory.
  hdr_t mem [DEPTH];
  hdr_t hdr_rd_r;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  hdr_t          mem_wd;
  logic [AW-1:0] rd_addr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    hdr_rd_r <= mem[rd_addr];
  end

  // Control and working registers.
  state_t state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [AW-1:0] top_r, top_nxt, bot_r, bot_nxt, brk_r, brk_nxt, head_r, head_nxt;
  logic [AW-1:0] cur_r, cur_nxt, prev_r, prev_nxt, best_r, best_nxt;
  logic [AW-1:0] best_sz_r, best_sz_nxt, len_r, len_nxt, h_r, h_nxt;
  logic [AW-1:0] left_r, left_nxt, lp_r, lp_nxt, right_r, right_nxt;
  logic [AW-1:0] pprev_r, pprev_nxt, tmp_r, tmp_nxt;
  logic [AW-1:0] hsz_r, hsz_nxt, hnx_r, hnx_nxt, res_addr_r, res_addr_nxt;
  logic [AW:0]   steps_r, steps_nxt;
  logic has_prev_r, has_prev_nxt, has_best_r, has_best_nxt;
  logic has_left_r, has_left_nxt, has_lp_r, has_lp_nxt;
  logic has_right_r, has_right_nxt, has_pprev_r, has_pprev_nxt;
  logic bad_r, bad_nxt;
  status_t res_st_r, res_st_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [AW-1:0] out_addr_r, out_addr_nxt, out_brk_r, out_brk_nxt;
  status_t out_st_r, out_st_nxt;

  // Shared arithmetic on the current request.
  logic [AW:0]   need_w;
  logic [AW-1:0] floor_a, rem_a, nh_a;
  logic [AW+1:0] nb_w;
  logic          nb_fail, in_fire, ptr_bad;

  assign need_w  = {1'b0, len_r} + (AW+1)'(HEADER_BYTES);
  assign floor_a = (bot_r == '0) ? AW'(1) : bot_r;
  assign rem_a   = AW'({1'b0, hdr_rd_r.size} - need_w);
  assign nh_a    = best_r + HB + rem_a;
  assign nb_w    = {2'b00, brk_r} - {1'b0, need_w};
  assign nb_fail = nb_w[AW+1] || (nb_w[AW:0] < {1'b0, floor_a})
                   || (nb_w[AW:0] > {1'b0, top_r});
  assign in_fire = in_item.valid && in_item.ready;
  assign ptr_bad = ({1'b0, in_item.block_address} < (AW+1)'(HEADER_BYTES + 1))
                   || (in_item.block_address < brk_r)
                   || (in_item.block_address < bot_r)
                   || (in_item.block_address > top_r);

  assign in_item.ready          = (state_r == S_IDLE);
  assign out_item.valid         = out_valid_r;
  assign out_item.address       = out_addr_r;
  assign out_item.status        = out_st_r;
  assign out_item.break_address = out_brk_r;

  // Sequencer.
  always_comb begin
    state_nxt = state_r;  clr_nxt = clr_r;
    top_nxt = top_r;  bot_nxt = bot_r;  brk_nxt = brk_r;  head_nxt = head_r;
    cur_nxt = cur_r;  prev_nxt = prev_r;  best_nxt = best_r;
    best_sz_nxt = best_sz_r;  len_nxt = len_r;  h_nxt = h_r;
    left_nxt = left_r;  lp_nxt = lp_r;  right_nxt = right_r;
    pprev_nxt = pprev_r;  tmp_nxt = tmp_r;  hsz_nxt = hsz_r;  hnx_nxt = hnx_r;
    res_addr_nxt = res_addr_r;  steps_nxt = steps_r;
    has_prev_nxt = has_prev_r;  has_best_nxt = has_best_r;
    has_left_nxt = has_left_r;  has_lp_nxt = has_lp_r;
    has_right_nxt = has_right_r;  has_pprev_nxt = has_pprev_r;
    bad_nxt = bad_r;  res_st_nxt = res_st_r;
    out_addr_nxt = out_addr_r;  out_st_nxt = out_st_r;  out_brk_nxt = out_brk_r;
    out_valid_nxt = out_valid_r && !out_item.ready;
    mem_we = 1'b0;  mem_wa = h_r;  mem_wd = '0;  rd_addr = h_r;

    unique case (state_r)
      S_CLR: begin
        mem_we = 1'b1;
        mem_wa = clr_r;
        clr_nxt = clr_r + AW'(1);
        if (&clr_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          len_nxt = in_item.request_length;
          h_nxt = in_item.block_address - HB;
          bad_nxt = ptr_bad;
          res_addr_nxt = '0;
          res_st_nxt = STAT_OK;
          cur_nxt = head_r;
          steps_nxt = '0;
          has_prev_nxt = 1'b0;
          has_best_nxt = 1'b0;
          state_nxt = (in_item.command == CMD_FREE) ? S_F_CK0 : S_A_RD;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_item.ready) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt = res_addr_r;
          out_st_nxt = res_st_r;
          out_brk_nxt = brk_r;
          state_nxt = S_IDLE;
        end
      end
      // Allocate: walk the list for an exact fit and the best split.
      S_A_RD: begin
        rd_addr = cur_r;
        if (cur_r == '0 || steps_r[AW]) begin
          state_nxt = S_A_FIT;
        end else begin
          state_nxt = S_A_CHK;
        end
      end
      S_A_CHK: begin
        if (hdr_rd_r.size == len_r) begin
          tmp_nxt = hdr_rd_r.next;
          rd_addr = prev_r;
          if (has_prev_r) begin
            state_nxt = S_A_L1;
          end else begin
            head_nxt = hdr_rd_r.next;
            state_nxt = S_A_L2;
          end
        end else begin
          if (({1'b0, hdr_rd_r.size} > need_w)
              && (!has_best_r || hdr_rd_r.size < best_sz_r)) begin
            best_nxt = cur_r;
            best_sz_nxt = hdr_rd_r.size;
            has_best_nxt = 1'b1;
          end
          prev_nxt = cur_r;
          has_prev_nxt = 1'b1;
          cur_nxt = hdr_rd_r.next;
          steps_nxt = steps_r + (AW+1)'(1);
          state_nxt = S_A_RD;
        end
      end
      S_A_L1: begin
        mem_we = 1'b1;
        mem_wa = prev_r;
        mem_wd = '{size: hdr_rd_r.size, next: tmp_r};
        state_nxt = S_A_L2;
      end
      S_A_L2: begin
        rd_addr = cur_r;
        state_nxt = S_A_L3;
      end
      S_A_L3: begin
        mem_we = 1'b1;
        mem_wa = cur_r;
        mem_wd = '{size: hdr_rd_r.size, next: '0};
        res_addr_nxt = cur_r + HB;
        state_nxt = S_FIN;
      end
      S_A_FIT: begin
        rd_addr = best_r;
        if (has_best_r) begin
          state_nxt = S_A_B1;
        end else if (nb_fail) begin
          res_st_nxt = STAT_NO_HEAP;
          state_nxt = S_FIN;
        end else begin
          brk_nxt = nb_w[AW-1:0];
          mem_we = 1'b1;
          mem_wa = nb_w[AW-1:0];
          mem_wd = '{size: len_r, next: '0};
          res_addr_nxt = nb_w[AW-1:0] + HB;
          state_nxt = S_FIN;
        end
      end
      S_A_B1: begin
        mem_we = 1'b1;
        mem_wa = best_r;
        mem_wd = '{size: rem_a, next: hdr_rd_r.next};
        tmp_nxt = nh_a;
        state_nxt = S_A_B2;
      end
      S_A_B2: begin
        mem_we = 1'b1;
        mem_wa = tmp_r;
        mem_wd = '{size: len_r, next: '0};
        res_addr_nxt = tmp_r + HB;
        state_nxt = S_FIN;
      end
      // Free: check the pointer and its header.
      S_F_CK0: begin
        if (bad_r) begin
          res_st_nxt = STAT_BAD_PTR;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_F_CK1;
        end
      end
      S_F_CK1: begin
        if ((top_r >= bot_r && hdr_rd_r.size >= top_r - bot_r)
            || hdr_rd_r.next != '0) begin
          res_st_nxt = STAT_BAD_PTR;
          state_nxt = S_FIN;
        end else begin
          has_left_nxt = 1'b0;
          has_lp_nxt = 1'b0;
          has_right_nxt = 1'b0;
          has_pprev_nxt = 1'b0;
          state_nxt = S_F_WRD;
        end
      end
      // Free: find the neighbors in the list.
      S_F_WRD: begin
        rd_addr = cur_r;
        if (cur_r == '0 || steps_r[AW]) begin
          state_nxt = S_F_S1;
        end else begin
          state_nxt = S_F_WCK;
        end
      end
      S_F_WCK: begin
        if (cur_r > h_r) begin
          lp_nxt = left_r;
          has_lp_nxt = has_left_r;
          left_nxt = cur_r;
          has_left_nxt = 1'b1;
          cur_nxt = hdr_rd_r.next;
          steps_nxt = steps_r + (AW+1)'(1);
          state_nxt = S_F_WRD;
        end else if (cur_r < h_r) begin
          right_nxt = cur_r;
          has_right_nxt = 1'b1;
          state_nxt = S_F_S1;
        end else begin
          res_st_nxt = STAT_DOUBLE_FREE;
          state_nxt = S_FIN;
        end
      end
      // Free: link the segment in.
      S_F_S1: begin
        if (has_left_r) begin
          rd_addr = left_r;
          state_nxt = S_F_S1B;
        end else begin
          state_nxt = S_F_S1A;
        end
      end
      S_F_S1A: begin
        mem_we = 1'b1;
        mem_wd = '{size: hdr_rd_r.size, next: head_r};
        head_nxt = h_r;
        state_nxt = S_F_S2;
      end
      S_F_S1B: begin
        mem_we = 1'b1;
        mem_wa = left_r;
        mem_wd = '{size: hdr_rd_r.size, next: h_r};
        tmp_nxt = hdr_rd_r.next;
        state_nxt = S_F_S1C;
      end
      S_F_S1C: begin
        state_nxt = S_F_S1D;
      end
      S_F_S1D: begin
        mem_we = 1'b1;
        mem_wd = '{size: hdr_rd_r.size, next: tmp_r};
        pprev_nxt = left_r;
        has_pprev_nxt = 1'b1;
        state_nxt = S_F_S2;
      end
      // Free: merge with the higher neighbor.
      S_F_S2: begin
        state_nxt = has_left_r ? S_F_S2A : S_F_S3;
      end
      S_F_S2A: begin
        rd_addr = left_r;
        if (seg_end(h_r, hdr_rd_r.size) == {2'b00, left_r}) begin
          hsz_nxt = hdr_rd_r.size;
          hnx_nxt = hdr_rd_r.next;
          state_nxt = S_F_S2B;
        end else begin
          state_nxt = S_F_S3;
        end
      end
      S_F_S2B: begin
        mem_we = 1'b1;
        mem_wd = '{size: hsz_r + hdr_rd_r.size + HB, next: hnx_r};
        state_nxt = S_F_S2C;
      end
      S_F_S2C: begin
        mem_we = 1'b1;
        mem_wa = left_r;
        state_nxt = S_F_S2D;
      end
      S_F_S2D: begin
        rd_addr = lp_r;
        pprev_nxt = lp_r;
        has_pprev_nxt = has_lp_r;
        if (has_lp_r) begin
          state_nxt = S_F_S2E;
        end else begin
          head_nxt = h_r;
          state_nxt = S_F_S3;
        end
      end
      S_F_S2E: begin
        mem_we = 1'b1;
        mem_wa = lp_r;
        mem_wd = '{size: hdr_rd_r.size, next: h_r};
        state_nxt = S_F_S3;
      end
      // Free: merge with the lower neighbor.
      S_F_S3: begin
        rd_addr = right_r;
        state_nxt = has_right_r ? S_F_S3A : S_F_S4;
      end
      S_F_S3A: begin
        if (seg_end(right_r, hdr_rd_r.size) == {2'b00, h_r}) begin
          hsz_nxt = hdr_rd_r.size;
          hnx_nxt = hdr_rd_r.next;
          state_nxt = S_F_S3B;
        end else begin
          state_nxt = S_F_S4;
        end
      end
      S_F_S3B: begin
        mem_we = 1'b1;
        mem_wa = right_r;
        mem_wd = '{size: hsz_r + hdr_rd_r.size + HB, next: hnx_r};
        state_nxt = S_F_S3C;
      end
      S_F_S3C: begin
        mem_we = 1'b1;
        h_nxt = right_r;
        state_nxt = S_F_S3D;
      end
      S_F_S3D: begin
        rd_addr = pprev_r;
        if (has_pprev_r) begin
          state_nxt = S_F_S3E;
        end else begin
          head_nxt = h_r;
          state_nxt = S_F_S4;
        end
      end
      S_F_S3E: begin
        mem_we = 1'b1;
        mem_wa = pprev_r;
        mem_wd = '{size: hdr_rd_r.size, next: h_r};
        state_nxt = S_F_S4;
      end
      // Free: a trailing free segment goes back to the break.
      S_F_S4: begin
        state_nxt = (h_r == brk_r) ? S_F_S4A : S_FIN;
      end
      S_F_S4A: begin
        if (hdr_rd_r.next == '0) begin
          brk_nxt = AW'(seg_end(h_r, hdr_rd_r.size));
          mem_we = 1'b1;
          state_nxt = S_F_S4B;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_F_S4B: begin
        rd_addr = pprev_r;
        if (has_pprev_r) begin
          state_nxt = S_F_S4C;
        end else begin
          head_nxt = '0;
          state_nxt = S_FIN;
        end
      end
      S_F_S4C: begin
        mem_we = 1'b1;
        mem_wa = pprev_r;
        mem_wd = '{size: hdr_rd_r.size, next: '0};
        state_nxt = S_FIN;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Register writes.
    if (cfg_we) begin
      unique case (cfg_index)
        REG_HEAP_TOP: begin
          top_nxt = cfg_data;
          brk_nxt = cfg_data;
          head_nxt = '0;
        end
        REG_HEAP_BOTTOM: begin
          bot_nxt = cfg_data;
        end
        default: begin
          bot_nxt = bot_r;
        end
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r <= '0;
      top_r <= AW'(TOP_RESET);
      bot_r <= AW'(BOTTOM_RESET);
      brk_r <= AW'(TOP_RESET);
      head_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      top_r <= top_nxt;
      bot_r <= bot_nxt;
      brk_r <= brk_nxt;
      head_r <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;  prev_r <= prev_nxt;  best_r <= best_nxt;
    best_sz_r <= best_sz_nxt;  len_r <= len_nxt;  h_r <= h_nxt;
    left_r <= left_nxt;  lp_r <= lp_nxt;  right_r <= right_nxt;
    pprev_r <= pprev_nxt;  tmp_r <= tmp_nxt;  hsz_r <= hsz_nxt;  hnx_r <= hnx_nxt;
    res_addr_r <= res_addr_nxt;  steps_r <= steps_nxt;
    has_prev_r <= has_prev_nxt;  has_best_r <= has_best_nxt;
    has_left_r <= has_left_nxt;  has_lp_r <= has_lp_nxt;
    has_right_r <= has_right_nxt;  has_pprev_r <= has_pprev_nxt;
    bad_r <= bad_nxt;  res_st_r <= res_st_nxt;
    out_addr_r <= out_addr_nxt;  out_st_r <= out_st_nxt;  out_brk_r <= out_brk_nxt;
  end

endmodule
